[hw/rtl/shc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the stepper axis homing controller.
// No dependencies; imported by every module of the block.
package shc_pkg;

  localparam int POSITION_BITS  = 20;
  localparam int COUNT_BITS     = 18;
  localparam int PERIOD_BITS    = 16;
  localparam int SHORT_BITS     = 12;  // pull-off steps and soft margin
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 18;

  localparam logic [PERIOD_BITS-1:0] MOVE_PERIOD_RST = PERIOD_BITS'(0);
  localparam logic [PERIOD_BITS-1:0] HOMING_PERIOD_RST = PERIOD_BITS'(312);
  localparam logic [PERIOD_BITS-1:0] CAL_PERIOD_RST = PERIOD_BITS'(100);
  localparam logic [COUNT_BITS-1:0] HOMING_MAX_RST = COUNT_BITS'(150000);
  localparam logic [SHORT_BITS-1:0] PULL_OFF_RST = SHORT_BITS'(100);
  localparam logic [COUNT_BITS-1:0] CAL_STEPS_RST = COUNT_BITS'(100000);
  localparam logic [SHORT_BITS-1:0] SOFT_MARGIN_RST = SHORT_BITS'(200);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MOVE_PERIOD   = 3'd0,
    REG_HOMING_PERIOD = 3'd1,
    REG_CAL_PERIOD    = 3'd2,
    REG_HOMING_MAX    = 3'd3,
    REG_PULL_OFF      = 3'd4,
    REG_CAL_STEPS     = 3'd5,
    REG_SOFT_MARGIN   = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_HOME = 2'd1,
    OP_MOVE = 2'd2,
    OP_CAL  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_BUSY   = 3'd1,
    ST_DONE   = 3'd2,
    ST_ESTOP  = 3'd3,
    ST_HARD   = 3'd4,
    ST_SOFT   = 3'd5,
    ST_HFAIL  = 3'd6,
    ST_REJECT = 3'd7
  } status_t;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_MOVE    = 6'b000010,
    PH_BACKOFF = 6'b000100,
    PH_SEEK    = 6'b001000,
    PH_PULLOFF = 6'b010000,
    PH_CAL     = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] move_period;
    logic [PERIOD_BITS-1:0] homing_period;
    logic [PERIOD_BITS-1:0] calibration_period;
    logic [COUNT_BITS-1:0]  homing_max_steps;
    logic [SHORT_BITS-1:0]  pull_off_steps;
    logic [COUNT_BITS-1:0]  calibration_steps;
    logic [SHORT_BITS-1:0]  soft_margin;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [COUNT_BITS-1:0] move_steps;
    logic                  move_toward_limit;
    logic                  limit_switch;
    logic                  estop;
  } in_item_t;

  typedef struct packed {
    logic                            step_pulse;
    logic                            step_dir;
    logic signed [POSITION_BITS-1:0] axis_position;
    logic signed [POSITION_BITS-1:0] max_position;
    logic                            is_homed;
    logic                            soft_limit_valid;
    logic [2:0]                      status;
  } out_item_t;

endpackage

[hw/rtl/shc_cfg.sv]
`timescale 1ns / 1ps
// Configuration register file for the stepper axis homing controller.
// Depends on shc_pkg.
module shc_cfg
  import shc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.move_period        <= MOVE_PERIOD_RST;
      cfg_r.homing_period      <= HOMING_PERIOD_RST;
      cfg_r.calibration_period <= CAL_PERIOD_RST;
      cfg_r.homing_max_steps   <= HOMING_MAX_RST;
      cfg_r.pull_off_steps     <= PULL_OFF_RST;
      cfg_r.calibration_steps  <= CAL_STEPS_RST;
      cfg_r.soft_margin        <= SOFT_MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MOVE_PERIOD:   cfg_r.move_period        <= cfg_data[PERIOD_BITS-1:0];
        REG_HOMING_PERIOD: cfg_r.homing_period      <= cfg_data[PERIOD_BITS-1:0];
        REG_CAL_PERIOD:    cfg_r.calibration_period <= cfg_data[PERIOD_BITS-1:0];
        REG_HOMING_MAX:    cfg_r.homing_max_steps   <= cfg_data[COUNT_BITS-1:0];
        REG_PULL_OFF:      cfg_r.pull_off_steps     <= cfg_data[SHORT_BITS-1:0];
        REG_CAL_STEPS:     cfg_r.calibration_steps  <= cfg_data[COUNT_BITS-1:0];
        REG_SOFT_MARGIN:   cfg_r.soft_margin        <= cfg_data[SHORT_BITS-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

endmodule

[hw/rtl/shc_core.sv]
`timescale 1ns / 1ps
// Axis state and per-tick update logic of the stepper axis homing controller.
// Depends on shc_pkg.
module shc_core
  import shc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,    // commit this tick's update
  input  cfg_t      cfg,
  input  in_item_t  item,
  output out_item_t result
);

  localparam logic signed [POSITION_BITS:0] POS_MAX =
    {2'b00, {(POSITION_BITS-1){1'b1}}};

  phase_t                   phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] far_r, far_nxt;
  logic [POSITION_BITS-1:0] soft_pos_r, soft_pos_nxt;
  logic                     soft_ok_r, soft_ok_nxt;
  logic                     homed_r, homed_nxt;
  logic [COUNT_BITS-1:0]    steps_r, steps_nxt;
  logic [PERIOD_BITS-1:0]   wait_r, wait_nxt;
  logic                     toward_r, toward_nxt;

  logic                     pulse;
  status_t                  status;
  logic                     run;
  logic                     do_step;
  logic                     step_toward;
  logic [PERIOD_BITS-1:0]   step_period;
  logic [POSITION_BITS-1:0] stepped_pos;
  logic                     soft_block;
  logic signed [POSITION_BITS:0] cal_sum;

  // soft limit only ever refuses steps away from the switch
  assign soft_block = soft_ok_r && ($signed(pos_r) <= $signed(soft_pos_r));
  assign cal_sum    = $signed({pos_r[POSITION_BITS-1], pos_r})
                    + $signed({{(POSITION_BITS+1-SHORT_BITS){1'b0}}, cfg.soft_margin});

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    far_nxt      = far_r;
    soft_pos_nxt = soft_pos_r;
    soft_ok_nxt  = soft_ok_r;
    homed_nxt    = homed_r;
    steps_nxt    = steps_r;
    wait_nxt     = wait_r;
    toward_nxt   = toward_r;
    status       = ST_IDLE;
    run          = 1'b0;
    do_step      = 1'b0;
    step_toward  = 1'b0;
    step_period  = cfg.move_period;
    stepped_pos  = pos_r;

    // command decode / wait countdown
    if (phase_r != PH_IDLE) begin
      if (item.estop) begin
        phase_nxt = PH_IDLE;
        wait_nxt  = '0;
        status    = ST_ESTOP;
      end else if (wait_r != '0) begin
        wait_nxt = wait_r - PERIOD_BITS'(1);
        status   = ST_BUSY;
      end else begin
        run = 1'b1;
      end
    end else if (item.opcode != OP_NONE) begin
      if (item.estop || (item.opcode == OP_CAL && !homed_r)) begin
        status = ST_REJECT;
      end else begin
        wait_nxt = '0;
        run      = 1'b1;
        case (item.opcode)
          OP_HOME: begin
            if (item.limit_switch) begin
              phase_nxt = PH_BACKOFF;
              steps_nxt = COUNT_BITS'(cfg.pull_off_steps);
            end else begin
              phase_nxt = PH_SEEK;
              steps_nxt = cfg.homing_max_steps;
            end
          end
          OP_MOVE: begin
            phase_nxt  = PH_MOVE;
            steps_nxt  = item.move_steps;
            toward_nxt = item.move_toward_limit;
          end
          default: begin
            phase_nxt = PH_CAL;
            steps_nxt = cfg.calibration_steps;
          end
        endcase
      end
    end

    // one step of the active phase, on the decoded values
    if (run) begin
      status = ST_BUSY;
      unique case (phase_nxt)
        PH_MOVE: begin
          if (steps_nxt == '0) begin
            phase_nxt = PH_IDLE;
            status    = ST_DONE;
          end else if (item.limit_switch && toward_nxt) begin
            phase_nxt = PH_IDLE;
            status    = ST_HARD;
          end else if (!toward_nxt && soft_block) begin
            phase_nxt = PH_IDLE;
            status    = ST_SOFT;
          end else begin
            do_step     = 1'b1;
            step_toward = toward_nxt;
          end
        end
        PH_BACKOFF: begin
          if (steps_nxt == '0 || soft_block) begin
            phase_nxt = PH_SEEK;
            steps_nxt = cfg.homing_max_steps;
          end else begin
            do_step = 1'b1;
          end
        end
        PH_SEEK: begin
          if (steps_nxt == '0) begin
            phase_nxt = PH_IDLE;
            status    = ST_HFAIL;
          end else if (item.limit_switch) begin
            pos_nxt   = '0;
            far_nxt   = '0;
            homed_nxt = 1'b1;
            phase_nxt = PH_PULLOFF;
            steps_nxt = COUNT_BITS'(cfg.pull_off_steps);
          end else begin
            do_step     = 1'b1;
            step_toward = 1'b1;
            step_period = cfg.homing_period;
          end
        end
        PH_PULLOFF: begin
          if (steps_nxt == '0) begin
            phase_nxt = PH_IDLE;
            status    = ST_DONE;
          end else begin
            do_step     = 1'b1;
            step_period = cfg.homing_period;
          end
        end
        PH_CAL: begin
          if (steps_nxt == '0) begin
            soft_pos_nxt = (cal_sum > POS_MAX) ? POS_MAX[POSITION_BITS-1:0]
                                               : cal_sum[POSITION_BITS-1:0];
            soft_ok_nxt  = 1'b1;
            phase_nxt    = PH_IDLE;
            status       = ST_DONE;
          end else begin
            do_step     = 1'b1;
            step_period = cfg.calibration_period;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          status    = ST_IDLE;
        end
      endcase
    end

    if (do_step) begin
      stepped_pos = pos_r + (step_toward ? POSITION_BITS'(1) : {POSITION_BITS{1'b1}});
      pos_nxt    = stepped_pos;
      toward_nxt = step_toward;
      if ($signed(stepped_pos) > $signed(far_r)) begin
        far_nxt = stepped_pos;
      end
      if (steps_nxt != '0) begin
        steps_nxt = steps_nxt - COUNT_BITS'(1);
      end
      wait_nxt = step_period;
    end
  end

  assign pulse = do_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pos_r      <= '0;
      far_r      <= '0;
      soft_pos_r <= '0;
      soft_ok_r  <= 1'b0;
      homed_r    <= 1'b0;
      steps_r    <= '0;
      wait_r     <= '0;
      toward_r   <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      far_r      <= far_nxt;
      soft_pos_r <= soft_pos_nxt;
      soft_ok_r  <= soft_ok_nxt;
      homed_r    <= homed_nxt;
      steps_r    <= steps_nxt;
      wait_r     <= wait_nxt;
      toward_r   <= toward_nxt;
    end
  end

  assign result.step_pulse       = pulse;
  assign result.step_dir         = toward_nxt;
  assign result.axis_position    = $signed(pos_nxt);
  assign result.max_position     = $signed(far_nxt);
  assign result.is_homed         = homed_nxt;
  assign result.soft_limit_valid = soft_ok_nxt;
  assign result.status           = status;

endmodule

[hw/rtl/stepper_axis_homing_controller.sv]
`timescale 1ns / 1ps
// Top level of the single-axis stepper homing and limit controller.
// Depends on shc_pkg, shc_cfg and shc_core.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one beat per control tick,
//   carrying the sampled limit switch and e-stop levels plus an optional
//   command (home, move, calibrate).
//   Result channel (out_valid / out_stall / out_data): exactly one beat per
//   input beat, in order: step pulse and direction, position, furthest
//   position, homed and soft-limit flags, and a status code.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; write only while the block holds no pending beats.
// Path: an input beat is accepted into the input register, then moves into
//   the result register, where out_valid rises; a stall can hold the beat in
//   either register.
// Throughput: one beat per cycle while out_stall is low; the whole tick
//   update is a single pass of logic between input and result registers.
// Reset (rst_n low, synchronous): pipeline emptied, axis state cleared to
//   idle at position zero, config registers back to their defaults.
// Stall: when out_stall holds a full result register, the input register
//   still takes one more beat; after that in_stall rises until the result
//   drains. Axis state only advances when a beat moves into the result reg.
module stepper_axis_homing_controller
  import shc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // input beats
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  // result beats
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data,
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;

  logic      advance;   // result register can take a beat
  logic      fire;      // input register beat moves to result register
  cfg_t      cfg;
  out_item_t result;

  assign advance  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  shc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  shc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .cfg    (cfg),
    .item   (in_item_r),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule
